/* rtl/core/psp_pkg.sv */
package psp_pkg;

  localparam int unsigned HeaderBytes  = 7;
  localparam logic [31:0] StreamTag    = 32'hbacabaca;
  localparam int unsigned RegionWidth  = 25;
  localparam int unsigned PacketWidth  = 14;
  localparam int unsigned CfgAddrWidth = 2;
  localparam int unsigned CfgDataWidth = RegionWidth;
  localparam int unsigned IdxWidth     = 4;

  typedef enum logic [CfgAddrWidth-1:0] {
    REG_PIXEL_FORMAT      = 2'd0,
    REG_CHANNEL_ID        = 2'd1,
    REG_REGION_PIXELS     = 2'd2,
    REG_PIXELS_PER_PACKET = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FMT_RGB565 = 2'd0,
    FMT_RGB    = 2'd1,
    FMT_RGBA   = 2'd2
  } pix_fmt_e;

  typedef struct packed {
    logic [1:0]             pixel_format;
    logic [7:0]             channel_id;
    logic [RegionWidth-1:0] region_pixels;
    logic [PacketWidth-1:0] pixels_per_packet;
  } cfg_t;

  // Everything the serializer needs to emit the bytes of one pixel.
  typedef struct packed {
    logic        hdr;
    logic [7:0]  channel_id;
    logic [15:0] len;
    logic [31:0] px;
    logic [2:0]  nbytes;
    logic        pe;
    logic        fe;
  } desc_t;

endpackage

/* rtl/core/psp_framer.sv */
module psp_framer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  psp_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  input  logic [7:0]    alpha_i,
  output psp_pkg::desc_t desc_o
);

  logic [psp_pkg::RegionWidth-1:0] fpl_q, fpl_d, fpl_eff, fpl_after;
  logic [psp_pkg::PacketWidth-1:0] ppl_q, ppl_d, ppl_eff, ppl_after, ppp, cnt;
  logic [1:0]  fmt_q, fmt_d, fmt;
  logic        new_frame, new_pkt;
  logic [2:0]  nbytes;
  logic [15:0] cnt_ext, len;
  logic [15:0] rgb565;

  always_comb begin
    new_frame = (fpl_q == '0);
    if (new_frame) begin
      fpl_eff = (cfg_i.region_pixels == '0) ? psp_pkg::RegionWidth'(1) : cfg_i.region_pixels;
      fmt     = cfg_i.pixel_format;
      ppl_eff = '0;
    end else begin
      fpl_eff = fpl_q;
      fmt     = fmt_q;
      ppl_eff = ppl_q;
    end
    new_pkt = (ppl_eff == '0);

    case (fmt)
      psp_pkg::FMT_RGB565: nbytes = 3'd2;
      psp_pkg::FMT_RGB:    nbytes = 3'd3;
      default:             nbytes = 3'd4;
    endcase

    ppp = (cfg_i.pixels_per_packet == '0) ? psp_pkg::PacketWidth'(1)
                                          : cfg_i.pixels_per_packet;
    // The remaining frame count only matters when it is below the packet size.
    cnt = (fpl_eff < psp_pkg::RegionWidth'(ppp)) ? fpl_eff[psp_pkg::PacketWidth-1:0] : ppp;
    cnt_ext = 16'(cnt);
    case (fmt)
      psp_pkg::FMT_RGB565: len = {cnt_ext[14:0], 1'b0};
      psp_pkg::FMT_RGB:    len = {cnt_ext[14:0], 1'b0} + cnt_ext;
      default:             len = {cnt_ext[13:0], 2'b00};
    endcase

    ppl_after = (new_pkt ? cnt : ppl_eff) - psp_pkg::PacketWidth'(1);
    fpl_after = fpl_eff - psp_pkg::RegionWidth'(1);

    fpl_d = fpl_after;
    ppl_d = (fpl_after == '0) ? '0 : ppl_after;
    fmt_d = fmt;

    rgb565 = {red_i[7:3], green_i[7:2], blue_i[7:3]};

    desc_o.hdr        = new_pkt;
    desc_o.channel_id = cfg_i.channel_id;
    desc_o.len        = len;
    desc_o.px         = (fmt == psp_pkg::FMT_RGB565) ? {16'h0000, rgb565}
                                                     : {alpha_i, blue_i, green_i, red_i};
    desc_o.nbytes     = nbytes;
    desc_o.pe         = (ppl_after == '0);
    desc_o.fe         = (fpl_after == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpl_q <= '0;
      ppl_q <= '0;
      fmt_q <= psp_pkg::FMT_RGB565;
    end else if (accept_i) begin
      fpl_q <= fpl_d;
      ppl_q <= ppl_d;
      fmt_q <= fmt_d;
    end
  end

endmodule

/* rtl/core/psp_serializer.sv */
module psp_serializer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psp_pkg::desc_t desc_i,
  input  logic           load_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_start_o,
  output logic           out_pe_o,
  output logic           out_fe_o
);

  psp_pkg::desc_t desc_q;
  logic                         busy_q;
  logic [psp_pkg::IdxWidth-1:0] idx_q, total, pix_idx;
  logic                         ov_q, start_q, pe_q, fe_q;
  logic [7:0]                   byte_q, byte_d;
  logic                         out_free, shift, last;

  always_comb begin
    total = desc_q.hdr ? psp_pkg::IdxWidth'(psp_pkg::HeaderBytes) + psp_pkg::IdxWidth'(desc_q.nbytes)
                       : psp_pkg::IdxWidth'(desc_q.nbytes);
    last  = (idx_q == total - psp_pkg::IdxWidth'(1));
    pix_idx = desc_q.hdr ? idx_q - psp_pkg::IdxWidth'(psp_pkg::HeaderBytes) : idx_q;

    if (desc_q.hdr && (idx_q < psp_pkg::IdxWidth'(psp_pkg::HeaderBytes))) begin
      case (idx_q)
        4'd0:    byte_d = desc_q.channel_id;
        4'd1:    byte_d = psp_pkg::StreamTag[7:0];
        4'd2:    byte_d = psp_pkg::StreamTag[15:8];
        4'd3:    byte_d = psp_pkg::StreamTag[23:16];
        4'd4:    byte_d = psp_pkg::StreamTag[31:24];
        4'd5:    byte_d = desc_q.len[7:0];
        default: byte_d = desc_q.len[15:8];
      endcase
    end else begin
      case (pix_idx[1:0])
        2'd0:    byte_d = desc_q.px[7:0];
        2'd1:    byte_d = desc_q.px[15:8];
        2'd2:    byte_d = desc_q.px[23:16];
        default: byte_d = desc_q.px[31:24];
      endcase
    end
  end

  assign out_free = !ov_q || out_ready_i;
  assign shift    = busy_q && out_free;
  // A new item may enter in the cycle the previous one hands over its last byte.
  assign ready_o  = !busy_q || (shift && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (shift) begin
      if (last) begin
        busy_q <= 1'b0;
      end
      idx_q <= idx_q + psp_pkg::IdxWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_free) begin
      ov_q <= shift;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      byte_q  <= byte_d;
      start_q <= desc_q.hdr && (idx_q == '0);
      pe_q    <= last && desc_q.pe;
      fe_q    <= last && desc_q.fe;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign out_start_o = start_q;
  assign out_pe_o    = pe_q;
  assign out_fe_o    = fe_q;

endmodule

/* rtl/core/pixel_stream_packetizer.sv */
// Each taken pixel is registered in the serializer, and its bytes leave through a registered output.
// Throughput: one byte per cycle on the byte-wide output unless m_axis_tready holds it off; a pixel
// has 2, 3 or 4 bytes, plus 7 header bytes when it opens a packet.
// The next pixel is taken in the cycle the previous one hands over its last byte.
// Reset (rst_ni low, asynchronous) clears the counters so the next pixel opens a new frame,
// and sets the registers to rgb565, channel 0, one pixel per region and per packet.
module pixel_stream_packetizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [psp_pkg::CfgAddrWidth-1:0]    cfg_addr_i,
  input  logic [psp_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [31:0]                         s_axis_tdata,   // red, green, blue, alpha
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // out_byte
  output logic                                m_axis_tlast,   // packet_end
  output logic [1:0]                          m_axis_tuser    // packet_start, frame_end
);

  psp_pkg::cfg_t  cfg_q;
  psp_pkg::desc_t desc;
  logic           accept;
  logic           start, pe, fe;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format      <= psp_pkg::FMT_RGB565;
      cfg_q.channel_id        <= '0;
      cfg_q.region_pixels     <= psp_pkg::RegionWidth'(1);
      cfg_q.pixels_per_packet <= psp_pkg::PacketWidth'(1);
    end else if (cfg_we_i) begin
      unique case (psp_pkg::cfg_reg_e'(cfg_addr_i))
        psp_pkg::REG_PIXEL_FORMAT:      cfg_q.pixel_format <= cfg_wdata_i[1:0];
        psp_pkg::REG_CHANNEL_ID:        cfg_q.channel_id <= cfg_wdata_i[7:0];
        psp_pkg::REG_REGION_PIXELS:     cfg_q.region_pixels <= cfg_wdata_i;
        psp_pkg::REG_PIXELS_PER_PACKET:
          cfg_q.pixels_per_packet <= cfg_wdata_i[psp_pkg::PacketWidth-1:0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  psp_framer u_framer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .red_i    (s_axis_tdata[7:0]),
    .green_i  (s_axis_tdata[15:8]),
    .blue_i   (s_axis_tdata[23:16]),
    .alpha_i  (s_axis_tdata[31:24]),
    .desc_o   (desc)
  );

  psp_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (desc),
    .load_i      (accept),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_start_o (start),
    .out_pe_o    (pe),
    .out_fe_o    (fe)
  );

  assign m_axis_tlast = pe;
  assign m_axis_tuser = {fe, start};

endmodule

/* rtl/core/psp_checker.sv */
module psp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  logic       out_acc;
  logic       after_end_q;
  logic [2:0] hdr_cnt_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Tracks whether the last byte taken closed a packet, and the position inside a header.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_end_q <= 1'b1;
      hdr_cnt_q   <= '0;
    end else if (out_acc) begin
      after_end_q <= m_axis_tlast;
      if (m_axis_tuser[0]) begin
        hdr_cnt_q <= 3'd1;
      end else if (hdr_cnt_q != '0) begin
        hdr_cnt_q <= (hdr_cnt_q == 3'd6) ? 3'd0 : hdr_cnt_q + 3'd1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("frame end without packet end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && m_axis_tuser[0] |-> after_end_q)
    else $error("packet started before the previous one ended");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (hdr_cnt_q != 3'd0) |-> !m_axis_tuser[0] && !m_axis_tlast)
    else $error("packet marker inside a header");

endmodule

bind pixel_stream_packetizer psp_checker u_psp_checker (.*);

/* tb/psp_stream_checker.sv */
// Watches the register port and both streams of the packetizer, predicts the byte stream of
// every accepted pixel and compares each byte that leaves the block with the oldest one due.
module psp_stream_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [psp_pkg::CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [psp_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,   // red, green, blue, alpha
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [7:0]                       m_axis_tdata,   // out_byte
  input  logic                             m_axis_tlast,   // packet_end
  input  logic [1:0]                       m_axis_tuser,   // packet_start, frame_end
  output int                               mismatches_o,
  output int                               pending_o,
  output int                               checked_o,
  output logic                             frame_open_o
);
  import psp_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
    logic       frame_end;
  } stream_byte_t;

  stream_byte_t expected_bytes[$];

  // Register copies.
  logic [1:0]             fmt_reg;
  logic [7:0]             chan_reg;
  logic [RegionWidth-1:0] region_reg;
  logic [PacketWidth-1:0] ppp_reg;

  // Framing state.
  logic [RegionWidth-1:0] frame_left;
  logic [PacketWidth-1:0] packet_left;
  logic [1:0]             frame_fmt;

  function automatic int unsigned pixel_bytes(logic [1:0] fmt);
    if (fmt == FMT_RGB565) return 2;
    if (fmt == FMT_RGB) return 3;
    return 4;
  endfunction

  task automatic push_byte(logic [7:0] data, logic start, logic last, logic frame_end);
    expected_bytes.push_back('{data: data, start: start, last: last, frame_end: frame_end});
  endtask

  task automatic predict_pixel(logic [31:0] pix);
    logic [7:0]             red, green, blue, alpha;
    logic [15:0]            packed565;
    logic [7:0]             payload [4];
    logic [PacketWidth-1:0] ppp;
    logic [RegionWidth-1:0] count;
    logic [15:0]            len;
    logic                   pkt_done, frm_done, last_one;
    int unsigned            nbytes;
    red   = pix[7:0];
    green = pix[15:8];
    blue  = pix[23:16];
    alpha = pix[31:24];
    // Region size and format are taken only when a new frame opens.
    if (frame_left == 0) begin
      frame_left  = (region_reg == 0) ? RegionWidth'(1) : region_reg;
      frame_fmt   = fmt_reg;
      packet_left = 0;
    end
    nbytes = pixel_bytes(frame_fmt);
    if (packet_left == 0) begin
      ppp         = (ppp_reg == 0) ? PacketWidth'(1) : ppp_reg;
      count       = (frame_left < RegionWidth'(ppp)) ? frame_left : RegionWidth'(ppp);
      len         = 16'(count * nbytes);
      packet_left = PacketWidth'(count);
      push_byte(chan_reg, 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++) push_byte(StreamTag[8*i +: 8], 1'b0, 1'b0, 1'b0);
      push_byte(len[7:0], 1'b0, 1'b0, 1'b0);
      push_byte(len[15:8], 1'b0, 1'b0, 1'b0);
    end
    if (frame_fmt == FMT_RGB565) begin
      packed565  = {red[7:3], green[7:2], blue[7:3]};
      payload[0] = packed565[7:0];
      payload[1] = packed565[15:8];
      payload[2] = 8'h00;
      payload[3] = 8'h00;
    end else begin
      payload[0] = red;
      payload[1] = green;
      payload[2] = blue;
      payload[3] = alpha;
    end
    packet_left = packet_left - 1'b1;
    frame_left  = frame_left - 1'b1;
    pkt_done    = (packet_left == 0);
    frm_done    = (frame_left == 0);
    if (frm_done) packet_left = 0;
    for (int unsigned i = 0; i < nbytes; i++) begin
      last_one = (i + 1 == nbytes);
      push_byte(payload[i], 1'b0, last_one & pkt_done, last_one & frm_done);
    end
  endtask

  task automatic check_byte();
    stream_byte_t want, got;
    got = '{data: m_axis_tdata, start: m_axis_tuser[0], last: m_axis_tlast,
            frame_end: m_axis_tuser[1]};
    if (expected_bytes.size() == 0) begin
      mismatches_o++;
      if (mismatches_o <= ReportLimit)
        $display("Unexpected output byte %02h (start %b last %b frame_end %b), none due",
                 got.data, got.start, got.last, got.frame_end);
    end else begin
      want = expected_bytes.pop_front();
      if (got !== want) begin
        mismatches_o++;
        if (mismatches_o <= ReportLimit)
          $display("Byte %0d: expected %02h start %b last %b frame_end %b, got %02h %b %b %b",
                   checked_o, want.data, want.start, want.last, want.frame_end,
                   got.data, got.start, got.last, got.frame_end);
      end
      checked_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_reg      = FMT_RGB565;
      chan_reg     = '0;
      region_reg   = RegionWidth'(1);
      ppp_reg      = PacketWidth'(1);
      frame_left   = '0;
      packet_left  = '0;
      frame_fmt    = FMT_RGB565;
      mismatches_o = 0;
      checked_o    = 0;
      expected_bytes.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_PIXEL_FORMAT:      fmt_reg = cfg_wdata_i[1:0];
          REG_CHANNEL_ID:        chan_reg = cfg_wdata_i[7:0];
          REG_REGION_PIXELS:     region_reg = cfg_wdata_i[RegionWidth-1:0];
          REG_PIXELS_PER_PACKET: ppp_reg = cfg_wdata_i[PacketWidth-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_byte();
    end
    pending_o    = expected_bytes.size();
    frame_open_o = (frame_left != 0);
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import psp_pkg::*;

  localparam logic [1:0] FmtUnused   = 2'd3;
  localparam int         CycleLimit  = 400000;
  localparam int         RandomItems = 300;
  localparam int         SettleTail  = 8;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgAddrWidth-1:0] cfg_addr_i;
  logic [CfgDataWidth-1:0] cfg_wdata_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [31:0]             s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [7:0]              m_axis_tdata;
  logic                    m_axis_tlast;
  logic [1:0]              m_axis_tuser;

  int   mismatches, pending, checked;
  logic frame_open;

  int   cycle_count = 0;
  int   items_sent  = 0;
  int   settings    = 0;
  int   rx_wait     = 0;
  logic tx_quiet    = 1'b0;
  logic rx_quiet    = 1'b0;

  pixel_stream_packetizer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  psp_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .frame_open_o (frame_open)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d bytes still due", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: after each accepted byte the receiver holds off for a drawn number of cycles.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) rx_wait = rx_quiet ? 0 : $urandom_range(0, 7);
  end

  always @(negedge clk_i) begin
    if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item was taken.
  task automatic send_pixel(logic [31:0] pix);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Only the registers selected by mask are written, one per cycle.
  task automatic write_config(logic [3:0] mask, logic [1:0] fmt, logic [7:0] chan,
                              logic [RegionWidth-1:0] region, logic [PacketWidth-1:0] ppp);
    logic [CfgDataWidth-1:0] vals [4];
    vals[REG_PIXEL_FORMAT]      = CfgDataWidth'(fmt);
    vals[REG_CHANNEL_ID]        = CfgDataWidth'(chan);
    vals[REG_REGION_PIXELS]     = CfgDataWidth'(region);
    vals[REG_PIXELS_PER_PACKET] = CfgDataWidth'(ppp);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_addr_i  <= cfg_reg_e'(i);
        cfg_wdata_i <= vals[i];
        cfg_we_i    <= 1'b1;
        @(negedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  initial begin
    int                     burst;
    logic [3:0]             mask;
    logic [1:0]             fmt;
    logic [RegionWidth-1:0] region;
    logic [PacketWidth-1:0] ppp;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_PIXEL_FORMAT;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: one-pixel rgb565 frames, all-ones and all-zeros colors.
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);
    drain();

    // Zero region and packet sizes act as one; the unused format code packs like rgba.
    write_config(4'hf, FmtUnused, 8'hff, '0, '0);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0403_0201);
    drain();

    write_config(4'hf, FMT_RGB, 8'ha5, 5, 2);
    send_pixel(32'h8080_8080);
    send_pixel(32'h7f7f_7f7f);
    send_pixel(32'h55aa_55aa);
    drain();
    // Mid frame: the format holds until the frame ends, channel and packet size
    // apply from the next packet, the region size from the next frame.
    write_config(4'hf, FMT_RGBA, 8'h5a, 7, 3);
    repeat (5) send_pixel($urandom());
    drain();

    while (items_sent < 12 + RandomItems) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      mask     = ($urandom_range(0, 1) == 0) ? 4'hf : 4'($urandom_range(1, 15));
      fmt      = ($urandom_range(0, 9) == 0) ? FmtUnused : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0:       region = '0;
        7, 8:    region = RegionWidth'($urandom_range(25, 80));
        9:       region = RegionWidth'($urandom_range(81, 150));
        default: region = RegionWidth'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        0:       ppp = '0;
        7, 8:    ppp = PacketWidth'($urandom_range(9, 64));
        9:       ppp = PacketWidth'($urandom_range(65, 16383));
        default: ppp = PacketWidth'($urandom_range(1, 8));
      endcase
      write_config(mask, fmt, 8'($urandom()), region, ppp);
      burst = $urandom_range(1, 30);
      repeat (burst) send_pixel($urandom());
      drain();
    end

    // Close the open frame so the largest sizes below start a frame of their own.
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    while (frame_open) send_pixel($urandom());
    drain();
    write_config(4'hf, FMT_RGBA, 8'h3c, {RegionWidth{1'b1}}, {PacketWidth{1'b1}});
    repeat (6) send_pixel($urandom());
    drain();
    write_config(4'h1, FMT_RGB565, '0, '0, '0);
    repeat (4) send_pixel($urandom());
    drain();
    repeat (SettleTail) @(negedge clk_i);

    $display("Checked %0d output bytes from %0d pixels under %0d register settings.",
             checked, items_sent, settings);
    $display("Formats included the unused code, zero sizes, mid-frame changes and max sizes.");
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
